>>> rtl/wlp_pkg.sv
// Shared constants and types for the windowed latency percentile block.
`default_nettype none

package wlp_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 128;
    localparam int SAMPLE_BITS  = 32;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Event kinds carried in tuser
    localparam logic [1:0] REQ_TX   = 2'd0;
    localparam logic [1:0] REQ_RX   = 2'd1;
    localparam logic [1:0] REQ_RTT  = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    // Register map
    localparam logic REG_PERIOD = 1'b0;
    localparam int PERIOD_W     = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

    // Rank = floor(n * pct / 100) via reciprocal multiply
    localparam int NUM_PCT    = 3;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = CNT_W + PCT_W;
    localparam int RANK_SHIFT = 26;
    localparam int RECIP_W    = 20;
    localparam int RANK_RECIP = ((1 << RANK_SHIFT) + 99) / 100;
    localparam int QUOT_W     = PROD_W + RECIP_W;
    localparam logic [PCT_W-1:0] PCT_TABLE [NUM_PCT] = '{7'd50, 7'd95, 7'd99};

    // Result packing
    localparam int OUT_W = 168;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

endpackage

`default_nettype wire

>>> rtl/wlp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module wlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/windowed_latency_percentiles.sv
// Link diagnostics: byte totals and round-trip percentiles over a sample window.
//
// Input stream (s_axis): tuser carries the event kind (tx bytes, rx bytes,
// rtt sample, tick), tdata the 32-bit value. Byte counts add to wrapping
// totals, rtt samples go into a 128-entry ring in RAM, ticks advance the
// report phase.
// On the tick that closes a report period one transaction leaves on the
// output stream (m_axis): both totals, p50/p95/p99 and the sample count.
// The percentiles come from a radix select that walks the window RAM once
// per sample bit, all three ranks in the same pass; an empty window skips
// the walk. The input is held off while a report is built. The result
// waits in an output register; the next event is accepted while it waits,
// and a following report only stalls at its final step until the receiver
// takes the previous one.
// Reset (synchronous, active low) clears totals, sample count, write
// pointer and phase, and sets report_period to 100. The APB port holds
// report_period at address 0 and must only be written while idle.
`default_nettype none

module windowed_latency_percentiles
    import wlp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // Event input
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,   // value
    input  wire logic [1:0]        s_axis_tuser,   // req_type
    // Report output
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_W-1:0]  m_axis_tdata    // tx_total, rx_total, p50_us,
                                                   // p95_us, p99_us, window_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RANK1  = 3'd1;
    localparam logic [2:0] S_RANK2  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]          r_state;
    logic [31:0]         r_tx;
    logic [31:0]         r_rx;
    logic [ADDR_W-1:0]   r_wp;
    logic [CNT_W-1:0]    r_valid;
    logic [PERIOD_W-1:0] r_phase;
    logic [PERIOD_W-1:0] r_period;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_rvld;
    t_sample             r_bitsel;
    t_sample             r_mask;
    t_sample             r_prefix [NUM_PCT];
    logic [CNT_W-1:0]    r_rank   [NUM_PCT];
    logic [CNT_W-1:0]    r_cnt    [NUM_PCT];
    logic [PROD_W-1:0]   r_prod   [NUM_PCT];
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [PERIOD_W-1:0] n_phase;
    logic                w_in_acc;
    logic                w_report;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_last;
    t_sample             w_rdata;
    logic [QUOT_W-1:0]   w_quot  [NUM_PCT];
    logic                w_match [NUM_PCT];
    logic                w_load;
    logic                w_cfg_wr;

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_load        = (r_state == S_FINISH) && (!r_out_valid || m_axis_tready);

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PERIOD);
    assign prdata   = (paddr[2] == REG_PERIOD) ? 32'(r_period) : 32'd0;

    // Tick phase and report decision
    assign n_phase  = r_phase + PERIOD_W'(1);
    assign w_report = (n_phase == '0) || (n_phase >= r_period);

    // Sample RAM
    assign w_ram_we = w_in_acc && (s_axis_tuser == REQ_RTT);
    assign w_last   = ADDR_W'(r_valid - CNT_W'(1));

    wlp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (SAMPLE_BITS'(s_axis_tdata)),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Per-lane rank division and prefix match
    always_comb begin
        for (int i = 0; i < NUM_PCT; i++) begin
            w_quot[i]  = QUOT_W'(r_prod[i]) * QUOT_W'(RANK_RECIP);
            w_match[i] = (((w_rdata ^ r_prefix[i]) & r_mask) == '0)
                         && ((w_rdata & r_bitsel) == '0);
        end
    end

    // Control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tx        <= '0;
            r_rx        <= '0;
            r_wp        <= '0;
            r_valid     <= '0;
            r_phase     <= '0;
            r_period    <= PERIOD_RESET;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_period <= pwdata[PERIOD_W-1:0];
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            r_rvld <= (r_state == S_SCAN);

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (s_axis_tuser)
                            REQ_TX: r_tx <= r_tx + s_axis_tdata;
                            REQ_RX: r_rx <= r_rx + s_axis_tdata;
                            REQ_RTT: begin
                                r_wp <= (r_wp == ADDR_W'(WINDOW_DEPTH - 1)) ?
                                        '0 : r_wp + ADDR_W'(1);
                                if (r_valid != CNT_W'(WINDOW_DEPTH)) begin
                                    r_valid <= r_valid + CNT_W'(1);
                                end
                            end
                            default: begin
                                if (w_report) begin
                                    r_phase <= '0;
                                    r_state <= (r_valid == '0) ? S_FINISH : S_RANK1;
                                end else begin
                                    r_phase <= n_phase;
                                end
                            end
                        endcase
                    end
                end
                S_RANK1:  r_state <= S_RANK2;
                S_RANK2:  r_state <= S_SCAN;
                S_SCAN: begin
                    if (r_addr == w_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN:  r_state <= S_UPDATE;
                S_UPDATE: r_state <= r_bitsel[0] ? S_FINISH : S_SCAN;
                S_FINISH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Radix select datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr   <= '0;
                r_bitsel <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                r_mask   <= '0;
                for (int i = 0; i < NUM_PCT; i++) begin
                    r_prefix[i] <= '0;
                    r_cnt[i]    <= '0;
                end
            end
            S_RANK1: begin
                for (int i = 0; i < NUM_PCT; i++) begin
                    r_prod[i] <= PROD_W'(r_valid) * PROD_W'(PCT_TABLE[i]);
                end
            end
            S_RANK2: begin
                for (int i = 0; i < NUM_PCT; i++) begin
                    r_rank[i] <= w_quot[i][RANK_SHIFT +: CNT_W];
                end
            end
            S_UPDATE: begin
                // Settle one bit of each order statistic, then narrow the prefix
                for (int i = 0; i < NUM_PCT; i++) begin
                    if (r_rank[i] >= r_cnt[i]) begin
                        r_prefix[i] <= r_prefix[i] | r_bitsel;
                        r_rank[i]   <= r_rank[i] - r_cnt[i];
                    end
                    r_cnt[i] <= '0;
                end
                r_bitsel <= r_bitsel >> 1;
                r_mask   <= r_mask | r_bitsel;
            end
            default: begin
            end
        endcase

        // Address walk over the valid entries
        if (r_state == S_SCAN) begin
            r_addr <= (r_addr == w_last) ? '0 : r_addr + ADDR_W'(1);
        end

        // Count entries below the split point, one read per cycle
        if (r_rvld) begin
            for (int i = 0; i < NUM_PCT; i++) begin
                if (w_match[i]) begin
                    r_cnt[i] <= r_cnt[i] + CNT_W'(1);
                end
            end
        end

        if (w_load) begin
            r_out_data <= {8'(r_valid), 32'(r_prefix[2]), 32'(r_prefix[1]),
                           32'(r_prefix[0]), r_rx, r_tx};
        end
    end

`ifndef SYNTHESIS
    // Sample count never passes the window depth
    a_valid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid <= CNT_W'(WINDOW_DEPTH))
        else $error("sample count beyond window depth");

    // Ring is only written while no select runs
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_IDLE))
        else $error("ring write during select");

    // Reads stay inside the valid part of the window
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_addr) < r_valid))
        else $error("select read outside window");

    // Remaining ranks stay below the sample count during the walk
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rank[0] < r_valid) && (r_rank[1] < r_valid)
                                && (r_rank[2] < r_valid))
        else $error("rank out of range");
`endif

endmodule

`default_nettype wire

>>> test/tb_windowed_latency_percentiles.sv
// Self-checking testbench for the windowed latency percentile block.
`timescale 1ns / 1ps

import wlp_pkg::*;

// Tracks the link statistics the block should hold and the reports still owed.
class percentile_board;
    typedef struct {
        logic [31:0] tx;
        logic [31:0] rx;
        logic [31:0] p50;
        logic [31:0] p95;
        logic [31:0] p99;
        logic [7:0]  cnt;
    } t_report;

    t_sample               ring [WINDOW_DEPTH];
    logic [ADDR_W-1:0]     wr_ptr;
    logic [CNT_W-1:0]      n_valid;
    logic [PERIOD_W-1:0]   phase;
    logic [PERIOD_W-1:0]   period;
    logic [31:0]           tx_sum;
    logic [31:0]           rx_sum;
    t_report               due [$];
    int                    errors;
    int                    events;
    int                    reports_due;
    int                    reports_checked;
    int                    settings;

    function new();
        wr_ptr          = '0;
        n_valid         = '0;
        phase           = '0;
        period          = PERIOD_RESET;
        tx_sum          = '0;
        rx_sum          = '0;
        errors          = 0;
        events          = 0;
        reports_due     = 0;
        reports_checked = 0;
        settings        = 0;
    endfunction

    // Register write as seen on the APB port; unmapped indexes are dropped
    function void write_reg(int unsigned idx, logic [31:0] data);
        if (idx == REG_PERIOD) begin
            period = data[PERIOD_W-1:0];
            settings++;
        end
    endfunction

    // One accepted event: update totals, window or phase; queue a report if due
    function void note_event(logic [1:0] kind, logic [31:0] val);
        t_report     r;
        t_sample     win [$];
        int unsigned n;
        events++;
        case (kind)
            REQ_TX: tx_sum += val;
            REQ_RX: rx_sum += val;
            REQ_RTT: begin
                ring[wr_ptr] = val;
                wr_ptr++;
                if (n_valid < WINDOW_DEPTH) n_valid++;
            end
            default: begin
                phase++;
                if (phase != 0 && phase < period) return;
                phase = '0;
                n = 32'(n_valid);
                r.tx  = tx_sum;
                r.rx  = rx_sum;
                r.cnt = n_valid;
                if (n == 0) begin
                    r.p50 = '0;
                    r.p95 = '0;
                    r.p99 = '0;
                end else begin
                    for (int i = 0; i < n; i++) win.push_back(ring[i]);
                    win.sort();
                    r.p50 = win[(n * PCT_TABLE[0]) / 100];
                    r.p95 = win[(n * PCT_TABLE[1]) / 100];
                    r.p99 = win[(n * PCT_TABLE[2]) / 100];
                end
                due.push_back(r);
                reports_due++;
            end
        endcase
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
        end
    endfunction

    // Compare one report transaction with the oldest one owed
    function void check_report(logic [OUT_W-1:0] d);
        t_report r;
        if (due.size() == 0) begin
            $error("report with none outstanding, tdata %h", d);
            errors++;
            return;
        end
        r = due.pop_front();
        match("tx_total", r.tx, d[31:0]);
        match("rx_total", r.rx, d[63:32]);
        match("p50_us", r.p50, d[95:64]);
        match("p95_us", r.p95, d[127:96]);
        match("p99_us", r.p99, d[159:128]);
        match("window_count", {24'd0, r.cnt}, {24'd0, d[167:160]});
        reports_checked++;
    endfunction
endclass

module tb_windowed_latency_percentiles;

    localparam int LIMIT_CYCLES  = 8_000_000;
    localparam int LONG_HOLD     = 15000;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 5000;
    localparam int RAND_ITEMS    = 400;
    localparam int MIN_REPORTS   = 48;
    localparam logic [2:0] ADDR_PERIOD = {REG_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;  // value
    logic [1:0]       s_axis_tuser = '0;  // req_type
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;       // tx_total, rx_total, p50_us, p95_us,
                                          // p99_us, window_count

    percentile_board board;
    int              cycles = 0;
    int              burst_left = 0;
    int              holds_asked = 0;
    int              holds_done = 0;

    windowed_latency_percentiles u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Report monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tdata);
    end

    // Receiver: random stretches of stall patterns, plus a long hold-off on request
    initial begin : rx_side
        int mode;
        int stretch;
        @(posedge i_clk);
        forever begin
            if (holds_asked != holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(1, 40);
                for (int k = 0; k < stretch; k++) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= (k % 4 == 3);
                        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one event and hold it until the block takes it
    task automatic send_event(input logic [1:0] kind, input logic [31:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_event(kind, val);
    endtask

    // Sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 3);
            2:       gap = $urandom_range(1, 8);
            default: gap = $urandom_range(10, 40);
        endcase
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_paced(input logic [1:0] kind, input logic [31:0] val);
        send_event(kind, val);
        pace_sender();
    endtask

    // APB write: setup cycle, then access until pready
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(32'(addr >> 2), data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed report, then let the block settle
    task automatic settle_block(input int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin : main
        int unsigned plan [10];
        int unsigned per;
        int          rand_items;
        int          phase_no;
        int          phase_len;
        int          roll;
        logic [1:0]  kind;
        logic [31:0] val;

        plan  = '{1, 3, 0, 2, 65535, 5, 1, 4, 8, 2};
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Totals wrap; a few ticks under the reset period report nothing
        send_paced(REQ_TX, 32'hFFFF_FFFF);
        send_paced(REQ_TX, 32'h0000_0001);
        send_paced(REQ_TX, 32'h1234_5678);
        send_paced(REQ_RX, 32'hFFFF_FFFF);
        send_paced(REQ_RX, 32'hFFFF_FFFF);
        send_paced(REQ_RX, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h5555_5555);
        send_paced(REQ_TICK, 32'hFFFF_FFFF);
        settle_block(SETTLE_CYCLES);

        // Unmapped write is dropped; period lowered below the phase; empty window
        apb_write(ADDR_UNUSED, 32'h0000_0005);
        apb_write(ADDR_PERIOD, 32'hFFFF_0001);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_RTT, 32'hFFFF_FFFF);
        send_paced(REQ_RTT, 32'h0000_0000);
        send_paced(REQ_RTT, 32'h0000_0007);
        send_paced(REQ_TICK, 32'hAAAA_AAAA);
        settle_block(SETTLE_CYCLES);

        // Zero period reports on every tick
        apb_write(ADDR_PERIOD, 32'h0000_0000);
        send_paced(REQ_RTT, 32'h8000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        settle_block(SETTLE_CYCLES);

        // Largest period, then lowered under the phase reached
        apb_write(ADDR_PERIOD, 32'h0000_FFFF);
        send_paced(REQ_RTT, 32'h0000_0005);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        settle_block(SETTLE_CYCLES);
        apb_write(ADDR_PERIOD, 32'h0000_0002);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        send_paced(REQ_TICK, 32'h0000_0000);
        settle_block(SETTLE_CYCLES);

        // Random phases, each under its own report period
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RAND_ITEMS || board.reports_due < MIN_REPORTS) begin
            per = (phase_no < 10) ? plan[phase_no] : $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) apb_write(ADDR_UNUSED, $urandom);
            apb_write(ADDR_PERIOD, {16'($urandom), per[15:0]});
            // first phase: receiver backs off long enough for the block to fill
            if (phase_no == 0) holds_asked++;
            phase_len = $urandom_range(40, 60);
            for (int i = 0; i < phase_len; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 15)      kind = REQ_TX;
                else if (roll < 30) kind = REQ_RX;
                else if (roll < 62) kind = REQ_RTT;
                else                kind = REQ_TICK;
                roll = $urandom_range(0, 9);
                if (roll == 0)                       val = 32'hFFFF_FFFF;
                else if (roll == 1)                  val = 32'h0000_0000;
                else if (kind == REQ_RTT && roll < 6) val = $urandom_range(0, 31);
                else                                 val = $urandom;
                send_paced(kind, val);
                rand_items++;
            end
            settle_block(SETTLE_CYCLES);
            phase_no++;
        end

        settle_block(DRAIN_CYCLES);
        $display("Run covered %0d events and %0d checked reports over %0d period settings,",
                 board.events, board.reports_checked, board.settings);
        $display("including one receiver hold-off of %0d cycles.", LONG_HOLD);
        if (board.errors == 0 && board.due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
